/* rtl/udp_flow_cache_with_aging_core_defines.svh */
// ----------------------------------------------------------------------------
// UDP flow cache assertion macros
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef UDP_FLOW_CACHE_WITH_AGING_CORE_DEFINES_SVH
`define UDP_FLOW_CACHE_WITH_AGING_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define UFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define UFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define UFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define UFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/ufc_pkg.sv */
// ----------------------------------------------------------------------------
// UDP flow cache package
// Shared types, codes and constants of the flow cache.
// ----------------------------------------------------------------------------
package ufc_pkg;

    localparam int UFC_DEPTH        = 64;
    localparam int LIFETIME_W       = 16;
    localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 16'd30;

    // Command codes
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Entry kinds: the two families, plus invalidated
    localparam logic [1:0] KIND_IPV4    = 2'd0;
    localparam logic [1:0] KIND_IPV6    = 2'd1;
    localparam logic [1:0] KIND_INVALID = 2'd2;

    localparam logic FAMILY_IPV4 = 1'b0;

    typedef struct packed {
        logic        cmd;
        logic        family;
        logic [63:0] remote_addr_hi;
        logic [63:0] remote_addr_lo;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] now_seconds;
    } ufc_req_t;

    typedef struct packed {
        logic is_new;
        logic stale_dropped;
        logic oldest_evicted;
    } ufc_rsp_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] addr_hi;
        logic [63:0] addr_lo;
        logic [15:0] local_port;
        logic [15:0] remote_port;
        logic [31:0] start_time;
    } ufc_entry_t;

    // Control from the sequencer to every cell
    typedef struct packed {
        logic capture;  // register match flags against the held key
        logic insert;   // shift the chain by one, new entry enters cell 0
    } ufc_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_UPD
    } ufc_state_t;

endpackage

/* rtl/ufc_cell.sv */
// ----------------------------------------------------------------------------
// UDP flow cache cell
// One entry of the flow chain: compares the held key, ages, shifts onward.
// ----------------------------------------------------------------------------
module ufc_cell
    import ufc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ufc_ctrl_t             ctrl,
    input  ufc_req_t              key,
    input  logic [LIFETIME_W-1:0] lifetime,
    input  logic                  in_range,
    input  ufc_entry_t            prev_entry,
    output ufc_entry_t            entry_out,
    output logic                  hit,
    output logic                  stale
);

    ufc_entry_t entry_reg;
    ufc_entry_t entry_next;
    logic       hit_reg;
    logic       hit_next;
    logic       stale_reg;
    logic       stale_next;
    logic       key_match;
    logic       addr_match;
    logic       fresh;
    logic [31:0] age;

    always_comb
    begin
        if (key.family == FAMILY_IPV4)
        begin
            addr_match = (entry_reg.addr_hi[63:32] == key.remote_addr_hi[63:32]);
        end
        else
        begin
            addr_match = (entry_reg.addr_hi == key.remote_addr_hi)
                      && (entry_reg.addr_lo == key.remote_addr_lo);
        end
        key_match = in_range
                 && (entry_reg.kind == {1'b0, key.family})
                 && (entry_reg.local_port == key.local_port)
                 && (entry_reg.remote_port == key.remote_port)
                 && addr_match;
        age   = key.now_seconds - entry_reg.start_time;
        fresh = (age < {16'd0, lifetime});
    end

    // Hand the entry on with the stale mark already applied
    always_comb
    begin
        entry_out = entry_reg;
        if (stale_reg)
        begin
            entry_out.kind = KIND_INVALID;
        end
    end

    always_comb
    begin
        hit_next   = hit_reg;
        stale_next = stale_reg;
        entry_next = entry_reg;
        if (ctrl.capture)
        begin
            hit_next   = key_match && fresh;
            stale_next = key_match && !fresh;
        end
        if (ctrl.insert)
        begin
            entry_next = prev_entry;
            stale_next = 1'b0;
            hit_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg   <= 1'b0;
            stale_reg <= 1'b0;
        end
        else
        begin
            hit_reg   <= hit_next;
            stale_reg <= stale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign hit   = hit_reg;
    assign stale = stale_reg;

endmodule

/* rtl/udp_flow_cache_with_aging_core.sv */
// ----------------------------------------------------------------------------
// UDP flow cache with aging
// Remembers recent UDP flows in a shifting chain of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready) carries one lookup or clear transaction.
//   rsp channel (valid/ready) returns exactly one result transaction for each
//   request: is_new, stale_dropped, oldest_evicted.
//   cfg_we/cfg_wdata write lifetime_seconds; write only while the block is idle.
// Steps: in the compare state every cell compares its entry against the
//   held key and registers its match flags; in the update state the flags
//   are reduced, the chain shifts and the result is written, once rsp is free.
//   A new request is accepted only as the previous one completes its update.
// The newest entry sits in cell 0; an insert shifts every cell one place up,
//   so the oldest entry falls off the end when the chain is full.
// Reset: the chain is empty, lifetime_seconds is 30. No clearing pass.
// Stall: while rsp is held, the result register keeps its value; one more
//   request is accepted and compared, then waits until the result is taken.
// ----------------------------------------------------------------------------
`include "udp_flow_cache_with_aging_core_defines.svh"

module udp_flow_cache_with_aging_core
    import ufc_pkg::*;
#(
    parameter int CACHE_DEPTH = UFC_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  ufc_req_t              req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output ufc_rsp_t              rsp,
    input  logic                  cfg_we,
    input  logic [LIFETIME_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(CACHE_DEPTH + 1);

    ufc_state_t            state_reg;
    ufc_state_t            state_next;
    ufc_req_t              key_reg;
    logic [LIFETIME_W-1:0] lifetime_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    ufc_rsp_t              rsp_reg;
    ufc_rsp_t              rsp_next;

    ufc_ctrl_t             ctrl;
    ufc_entry_t            new_entry;
    ufc_entry_t            chain [CACHE_DEPTH];
    logic [CACHE_DEPTH-1:0] hit_bits;
    logic [CACHE_DEPTH-1:0] stale_bits;
    logic [CACHE_DEPTH-1:0] in_range;
    logic                  rsp_free;
    logic                  finish;
    logic                  any_hit;
    logic                  any_stale;
    logic                  full;

    // At most one live entry matches a key, so a plain OR gives the match
    assign any_hit   = |hit_bits;
    assign any_stale = |stale_bits;
    assign full      = (count_reg == CNT_W'(CACHE_DEPTH));
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign finish    = (state_reg == ST_UPD) && rsp_free;

    assign new_entry.kind        = {1'b0, key_reg.family};
    assign new_entry.addr_hi     = key_reg.remote_addr_hi;
    assign new_entry.addr_lo     = key_reg.remote_addr_lo;
    assign new_entry.local_port  = key_reg.local_port;
    assign new_entry.remote_port = key_reg.remote_port;
    assign new_entry.start_time  = key_reg.now_seconds;

    assign ctrl.capture = (state_reg == ST_CMP);
    assign ctrl.insert  = finish && (key_reg.cmd == CMD_LOOKUP) && !any_hit;

    // Sequencer: accept, compare, update
    always_comb
    begin
        state_next     = state_reg;
        req_ready      = 1'b0;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_UPD;
            end
            ST_UPD:
            begin
                if (rsp_free)
                begin
                    req_ready      = 1'b1;
                    state_next     = req_valid ? ST_CMP : ST_IDLE;
                    rsp_valid_next = 1'b1;
                    rsp_next       = '0;
                    if (key_reg.cmd == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (!any_hit)
                    begin
                        rsp_next.is_new         = 1'b1;
                        rsp_next.stale_dropped  = any_stale;
                        rsp_next.oldest_evicted = full;
                        if (!full)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            lifetime_reg  <= LIFETIME_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                lifetime_reg <= cfg_wdata;
            end
        end
    end

    // Hold the key of the transaction in flight, and the result register
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            key_reg <= req;
        end
        rsp_reg <= rsp_next;
    end

    // Build the cell chain; cell 0 holds the newest entry
    for (genvar i = 0; i < CACHE_DEPTH; i++)
    begin : g_cell
        ufc_entry_t prev;

        assign in_range[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_head
            assign prev = new_entry;
        end
        else
        begin : g_link
            assign prev = chain[i-1];
        end

        ufc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (key_reg),
            .lifetime   (lifetime_reg),
            .in_range   (in_range[i]),
            .prev_entry (prev),
            .entry_out  (chain[i]),
            .hit        (hit_bits[i]),
            .stale      (stale_bits[i])
        );
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `UFC_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(CACHE_DEPTH))
    `UFC_ASSERT_IMPL(a_single_match, clk, rst_n, state_reg == ST_UPD, $countones({hit_bits, stale_bits}) <= 1)
    `UFC_ASSERT_IMPL(a_evict_is_new, clk, rst_n, rsp_valid_reg && rsp_reg.oldest_evicted, rsp_reg.is_new)
    `UFC_ASSERT_NEXT(a_clear_empties, clk, rst_n, finish && (key_reg.cmd == CMD_CLEAR), count_reg == '0)
    `UFC_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctrl.insert && !full, count_reg == $past(count_reg) + 1'b1)

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flow cache with aging testbench
// Drives lookup and clear transactions into the flow cache under random
// backpressure, tracks the cache contents in a local ring, and checks every
// result flag against the expected outcome.
// ----------------------------------------------------------------------------
module testbench;
    import ufc_pkg::*;

    localparam int       POOL_SIZE   = 24;    // keys that recur in the random part
    localparam int       STALL_LIMIT = 2000;  // cycles without any transaction
    localparam int       NO_CFG      = -1;    // table row leaves lifetime alone
    localparam logic     FAMILY_IPV6 = 1'b1;

    // Result codes as they read in the stimulus table
    localparam ufc_rsp_t RSP_NONE  = 3'b000;  // hit, or clear
    localparam ufc_rsp_t RSP_NEW   = 3'b100;  // miss, inserted
    localparam ufc_rsp_t RSP_STALE = 3'b110;  // expired match dropped, reinserted

    // Directed keys
    localparam logic [63:0] V4_A = 64'hC0A8_0001_DEAD_BEEF;
    localparam logic [63:0] V4_C = 64'h0A00_0001_0000_0000;
    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [15:0] lport;
        logic [15:0] rport;
        logic [31:0] t0;
    } flow_rec_t;

    typedef struct {
        int       life_wr;
        ufc_req_t item;
        bit       typed;
        ufc_rsp_t exp;
    } dir_row_t;

    // DUT signals; every input starts at a known value
    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            req_valid = 1'b0;
    logic            req_ready;
    ufc_req_t        req       = '0;
    logic            rsp_valid;
    logic            rsp_ready = 1'b0;
    ufc_rsp_t        rsp;
    logic            cfg_we    = 1'b0;
    logic [15:0]     cfg_wdata = '0;

    // Side band that travels with each request: a typed-in expectation
    bit              req_typed = 1'b0;
    ufc_rsp_t        req_exp   = '0;

    // Flow ring as the cache should hold it
    flow_rec_t       flow_tab [UFC_DEPTH];
    int              ring_head = 0;
    int              ring_fill = 0;
    logic [15:0]     life_s    = LIFETIME_RESET;

    ufc_rsp_t        flow_exp_q[$];
    dir_row_t        dir_rows[$];
    int              fail_count = 0;
    bit              idle_on    = 1'b0;
    int              stall_left = 0;
    int              quiet_cycles = 0;

    udp_flow_cache_with_aging_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Apply one transaction to the flow ring and return the flags it should
    // produce. Scan oldest to newest, stop at the first key match.
    function automatic ufc_rsp_t predict_flow(ufc_req_t r);
        ufc_rsp_t    res;
        int          slot;
        logic [31:0] age;
        res = '0;
        if (r.cmd == CMD_CLEAR)
        begin
            ring_head = 0;
            ring_fill = 0;
            return res;
        end
        for (int i = 0; i < ring_fill; i++)
        begin
            slot = (ring_head + i) % UFC_DEPTH;
            // IPv4 keys compare only the upper half of addr_hi
            if (flow_tab[slot].kind == {1'b0, r.family} &&
                flow_tab[slot].lport == r.local_port &&
                flow_tab[slot].rport == r.remote_port &&
                ((r.family == FAMILY_IPV4) ?
                    (flow_tab[slot].hi[63:32] == r.remote_addr_hi[63:32]) :
                    (flow_tab[slot].hi == r.remote_addr_hi &&
                     flow_tab[slot].lo == r.remote_addr_lo)))
            begin
                age = r.now_seconds - flow_tab[slot].t0;  // wraps mod 2^32
                if (age < {16'd0, life_s})
                    return res;
                // Expired: the slot stays in the ring but never matches again
                flow_tab[slot].kind = KIND_INVALID;
                res.stale_dropped = 1'b1;
                break;
            end
        end
        if (ring_fill >= UFC_DEPTH)
        begin
            ring_head = (ring_head + 1) % UFC_DEPTH;
            ring_fill = UFC_DEPTH - 1;
            res.oldest_evicted = 1'b1;
        end
        slot = (ring_head + ring_fill) % UFC_DEPTH;
        flow_tab[slot] = {1'b0, r.family, r.remote_addr_hi, r.remote_addr_lo,
                          r.local_port, r.remote_port, r.now_seconds};
        ring_fill++;
        res.is_new = 1'b1;
        return res;
    endfunction

    function automatic ufc_req_t mk_req(logic cmd, logic fam, logic [63:0] hi,
                                        logic [63:0] lo, logic [15:0] lp,
                                        logic [15:0] rp, logic [31:0] now);
        return {cmd, fam, hi, lo, lp, rp, now};
    endfunction

    function automatic ufc_req_t rand_req();
        ufc_req_t r;
        r.cmd            = CMD_LOOKUP;
        r.family         = 1'($urandom_range(0, 1));
        r.remote_addr_hi = {$urandom, $urandom};
        r.remote_addr_lo = {$urandom, $urandom};
        r.local_port     = 16'($urandom_range(0, 65535));
        r.remote_port    = 16'($urandom_range(0, 65535));
        r.now_seconds    = $urandom;
        return r;
    endfunction

    function automatic void add_row(int life_wr, ufc_req_t item, bit typed,
                                    ufc_rsp_t exp);
        dir_rows.push_back('{life_wr, item, typed, exp});
    endfunction

    // Present one transaction and hold it until accepted, then maybe idle.
    task automatic send_flow(ufc_req_t item, bit typed, ufc_rsp_t exp);
        req_valid <= 1'b1;
        req       <= item;
        req_typed <= typed;
        req_exp   <= exp;
        do @(posedge clk); while (!(req_valid && req_ready));
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    // Drop valid, drain every outstanding result, then write the lifetime.
    task automatic write_lifetime(logic [15:0] v);
        req_valid <= 1'b0;
        do @(posedge clk); while (flow_exp_q.size() != 0);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Result sink: random stall bursts while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(1, 17) - 1;
        end
        else
            rsp_ready <= 1'b1;
    end

    // Monitor: check the result first (it belongs to an older transaction),
    // then predict the one accepted in this cycle.
    always @(posedge clk)
    begin
        ufc_rsp_t want;
        ufc_rsp_t guess;
        if (rst_n)
        begin
            if (cfg_we)
                life_s = cfg_wdata;
            if (rsp_valid && rsp_ready)
            begin
                if (flow_exp_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %b at %0t", rsp, $realtime);
                end
                else
                begin
                    want = flow_exp_q.pop_front();
                    if (rsp.is_new !== want.is_new ||
                        rsp.stale_dropped !== want.stale_dropped ||
                        rsp.oldest_evicted !== want.oldest_evicted)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch at %0t: is_new %b/%b stale %b/%b evict %b/%b",
                                     $realtime, want.is_new, rsp.is_new,
                                     want.stale_dropped, rsp.stale_dropped,
                                     want.oldest_evicted, rsp.oldest_evicted);
                    end
                end
            end
            if (req_valid && req_ready)
            begin
                guess = predict_flow(req);
                flow_exp_q.push_back(req_typed ? req_exp : guess);
            end
        end
    end

    // Watchdog: end the run if no transaction moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        ufc_req_t    pool [POOL_SIZE];
        ufc_req_t    item;
        logic [31:0] clock_s;
        logic [15:0] life;
        int          pick;

        // Directed table. Lifetime stays at its reset value of 30 until the
        // first row that writes it.
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_A, 64'd0,
                               16'h0000, 16'd53, 32'd0), 1, RSP_NEW);
        // IPv4: low address bits and addr_lo are ignored
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, 64'hC0A8_0001_0000_0000,
                               ONES, 16'h0000, 16'd53, 32'd29), 1, RSP_NONE);
        // age equal to the lifetime is stale
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_A, 64'd0,
                               16'h0000, 16'd53, 32'd30), 1, RSP_STALE);
        // the invalidated copy is skipped, the reinserted one hits
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_A, 64'd0,
                               16'h0000, 16'd53, 32'd31), 1, RSP_NONE);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, ONES, ONES,
                               16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1, RSP_NEW);
        // one bit of addr_lo differs for IPv6
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, ONES, 64'hFFFF_FFFF_FFFF_FFFE,
                               16'hFFFF, 16'hFFFF, 32'd5), 1, RSP_NEW);
        // time wraps past zero: age 29
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, ONES, ONES,
                               16'hFFFF, 16'hFFFF, 32'h0000_001C), 1, RSP_NONE);
        // same bits, other family
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, ONES, ONES,
                               16'hFFFF, 16'hFFFF, 32'h0000_001C), 1, RSP_NEW);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, ONES, ONES,
                               16'hFFFE, 16'hFFFF, 32'h0000_001C), 1, RSP_NEW);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, ONES, ONES,
                               16'hFFFF, 16'hFFFE, 32'h0000_001C), 1, RSP_NEW);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, 64'd0, 64'd0,
                               16'h0000, 16'h0000, 32'd0), 1, RSP_NEW);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, 64'd1, 64'd0,
                               16'h0000, 16'h0000, 32'd0), 1, RSP_NEW);
        // clear ignores every other field
        add_row(NO_CFG, mk_req(CMD_CLEAR, FAMILY_IPV6, ONES, ONES,
                               16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF), 1, RSP_NONE);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, ONES, ONES,
                               16'hFFFF, 16'hFFFF, 32'h0000_001D), 1, RSP_NEW);
        // lifetime zero: every match is stale
        add_row(0, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_A, 64'd0,
                          16'h0000, 16'd53, 32'd100), 1, RSP_NEW);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_A, 64'd0,
                               16'h0000, 16'd53, 32'd100), 1, RSP_STALE);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_A, 64'd0,
                               16'h0000, 16'd53, 32'd100), 1, RSP_STALE);
        // largest lifetime
        add_row(65535, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_C, 64'd0,
                              16'd1234, 16'd80, 32'd1000), 1, RSP_NEW);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_C, 64'd0,
                               16'd1234, 16'd80, 32'd66534), 1, RSP_NONE);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_C, 64'd0,
                               16'd1234, 16'd80, 32'd66535), 1, RSP_STALE);
        // smallest nonzero lifetime
        add_row(1, mk_req(CMD_LOOKUP, FAMILY_IPV6, 64'h2001_0DB8_0000_0000,
                          64'h0000_0000_0000_0001, 16'd5353, 16'd5353, 32'd7), 1, RSP_NEW);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, 64'h2001_0DB8_0000_0000,
                               64'h0000_0000_0000_0001, 16'd5353, 16'd5353, 32'd7),
                1, RSP_NONE);
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV6, 64'h2001_0DB8_0000_0000,
                               64'h0000_0000_0000_0001, 16'd5353, 16'd5353, 32'd8),
                1, RSP_STALE);
        // several stored copies of A with older times: leave it to the ring
        add_row(NO_CFG, mk_req(CMD_LOOKUP, FAMILY_IPV4, V4_A, 64'd0,
                               16'h0000, 16'd53, 32'd9), 0, RSP_NONE);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].life_wr != NO_CFG)
                write_lifetime(16'(dir_rows[i].life_wr));
            send_flow(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].exp);
        end

        // Random part: a pool of recurring flows, fresh flows that fill the
        // ring to eviction, and a rare clear. Time crawls so that ages land
        // on both sides of the lifetime, with an occasional jump.
        for (int k = 0; k < POOL_SIZE; k++)
            pool[k] = rand_req();
        clock_s = $urandom;
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0:       life = 16'($urandom_range(2, 12));
                1:       life = 16'hFFFF;
                2:       life = 16'd1;
                3:       life = 16'($urandom_range(1, 65535));
                4:       life = 16'($urandom_range(8, 40));
                5:       life = 16'd0;
                default: life = 16'($urandom_range(10, 30));
            endcase
            write_lifetime(life);
            if ($urandom_range(0, 2) == 0)
                clock_s = 32'hFFFF_FF00 | $urandom_range(0, 255);  // cross the wrap
            for (int n = 0; n < 200; n++)
            begin
                // Re-roll idling every 50 transactions; the last phase runs flat out
                if (n % 50 == 0)
                    idle_on = (ph != 6) && ($urandom_range(0, 3) != 0);
                pick = $urandom_range(0, 299);
                if (pick == 0)
                begin
                    item = rand_req();
                    item.cmd = CMD_CLEAR;
                end
                else if (pick < 75)
                begin
                    item = rand_req();
                    pool[$urandom_range(0, POOL_SIZE - 1)] = item;
                end
                else
                begin
                    item = pool[$urandom_range(0, POOL_SIZE - 1)];
                    if (item.family == FAMILY_IPV4)
                    begin
                        item.remote_addr_hi[31:0] = $urandom;
                        item.remote_addr_lo       = {$urandom, $urandom};
                    end
                    if ($urandom_range(0, 9) == 0)
                        item.family = ~item.family;  // near miss on family
                end
                if ($urandom_range(0, 99) == 0)
                    clock_s = clock_s + $urandom;
                else
                    clock_s = clock_s + $urandom_range(0, 1);
                item.now_seconds = clock_s;
                send_flow(item, 1'b0, RSP_NONE);
            end
        end

        // Drain, then keep watching for stray results
        req_valid <= 1'b0;
        idle_on = 1'b0;
        do @(posedge clk); while (flow_exp_q.size() != 0);
        repeat (8) @(posedge clk);

        if (fail_count == 0 && flow_exp_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
